@@ design/eps_pkg.sv @@
// ----------------------------------------------------------------------------
// eps_pkg
// Shared constants, codes and types of the edge pair set.
// ----------------------------------------------------------------------------
`default_nettype none

package eps_pkg;

  localparam int MAX_PAIRS   = 256;
  localparam int NODE_BITS   = 16;
  localparam int IN_NODE_W   = 16;
  localparam int KIND_W      = 2;
  localparam int COUNT_OUT_W = 9;
  localparam int ADDR_W      = $clog2(MAX_PAIRS);
  localparam int CNT_W       = $clog2(MAX_PAIRS + 1);
  localparam int KEY_W       = 2 * NODE_BITS;

  // Request kinds; every other code acts as a check.
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
  } eps_mem_req_t;

  typedef struct packed {
    logic                   found;
    logic                   changed;
    logic                   full_refused;
    logic [COUNT_OUT_W-1:0] entry_count;
  } eps_result_t;

  // Keep only the low NODE_BITS of each node index.
  function automatic logic [KEY_W-1:0] make_key(input logic [IN_NODE_W-1:0] src,
                                                input logic [IN_NODE_W-1:0] dst);
    logic [NODE_BITS-1:0] s;
    logic [NODE_BITS-1:0] d;
    s = NODE_BITS'(src);
    d = NODE_BITS'(dst);
    return {s, d};
  endfunction

endpackage

`default_nettype wire

@@ design/eps_if.sv @@
// ----------------------------------------------------------------------------
// eps_if
// Valid/ready channels for requests and results of the edge pair set.
// ----------------------------------------------------------------------------
`default_nettype none

interface eps_req_if
  import eps_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [IN_NODE_W-1:0] source_node;
  logic [IN_NODE_W-1:0] dest_node;

  modport source (output valid, output kind, output source_node, output dest_node,
                  input ready);
  modport sink   (input valid, input kind, input source_node, input dest_node,
                  output ready);
endinterface

interface eps_rsp_if
  import eps_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic                   changed;
  logic                   full_refused;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output found, output changed, output full_refused,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input changed, input full_refused,
                  input entry_count, output ready);
endinterface

`default_nettype wire

@@ design/eps_store.sv @@
// ----------------------------------------------------------------------------
// eps_store
// Pair storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eps_store
  import eps_pkg::*;
(
  input  wire logic         clk,
  input  wire eps_mem_req_t mem_req,
  output logic [KEY_W-1:0]  rd_data
);

  logic [KEY_W-1:0] mem [MAX_PAIRS];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/eps_ctrl.sv @@
// ----------------------------------------------------------------------------
// eps_ctrl
// Sequencer: scans the store for a pair, appends, or shifts entries down.
// ----------------------------------------------------------------------------
`default_nettype none

module eps_ctrl
  import eps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  eps_req_if.sink          in_req,
  input  wire logic        slot_free,
  output logic             res_load,
  output eps_result_t      res,
  output eps_mem_req_t     mem_req,
  input  wire logic [KEY_W-1:0] rd_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT, ST_RESP} state_t;

  state_t            state_r,   state_nxt;
  logic [KIND_W-1:0] kind_r,    kind_nxt;
  logic [KEY_W-1:0]  key_r,     key_nxt;
  logic [CNT_W-1:0]  count_r,   count_nxt;
  logic [CNT_W-1:0]  idx_r,     idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  eps_result_t       res_r,     res_nxt;

  logic             hit;
  logic [CNT_W-1:0] shift_dst;

  assign hit       = cmp_vld_r && (rd_data == key_r);
  assign shift_dst = cmp_idx_r - CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    res_nxt     = res_r;
    mem_req     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          kind_nxt    = in_req.kind;
          key_nxt     = make_key(in_req.source_node, in_req.dest_node);
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end

      // One read issued per cycle, compared in the cycle after.
      ST_SCAN: begin
        priority if (hit) begin
          if (kind_r == KIND_REMOVE) begin
            idx_nxt     = cmp_idx_r + CNT_W'(1);
            cmp_vld_nxt = 1'b0;
            state_nxt   = ST_SHIFT;
          end else begin
            res_nxt   = '{found: 1'b1, changed: 1'b0, full_refused: 1'b0,
                          entry_count: COUNT_OUT_W'(count_r)};
            state_nxt = ST_RESP;
          end
        end else if (!cmp_vld_r && idx_r >= count_r) begin
          res_nxt = '{found: 1'b0, changed: 1'b0, full_refused: 1'b0,
                      entry_count: COUNT_OUT_W'(count_r)};
          if (kind_r == KIND_ADD) begin
            if (count_r == CNT_W'(MAX_PAIRS)) begin
              res_nxt.full_refused = 1'b1;
            end else begin
              // append at the end
              mem_req.wr_en       = 1'b1;
              mem_req.wr_addr     = count_r[ADDR_W-1:0];
              mem_req.wr_data     = key_r;
              count_nxt           = count_r + CNT_W'(1);
              res_nxt.changed     = 1'b1;
              res_nxt.entry_count = COUNT_OUT_W'(count_r + CNT_W'(1));
            end
          end
          state_nxt = ST_RESP;
        end else begin
          if (idx_r < count_r) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_r[ADDR_W-1:0];
            idx_nxt         = idx_r + CNT_W'(1);
            cmp_vld_nxt     = 1'b1;
            cmp_idx_nxt     = idx_r;
          end else begin
            cmp_vld_nxt = 1'b0;
          end
        end
      end

      // Read entry i, write it back at i-1 on the next cycle.
      ST_SHIFT: begin
        if (cmp_vld_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = shift_dst[ADDR_W-1:0];
          mem_req.wr_data = rd_data;
        end
        if (idx_r < count_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r[ADDR_W-1:0];
          idx_nxt         = idx_r + CNT_W'(1);
          cmp_vld_nxt     = 1'b1;
          cmp_idx_nxt     = idx_r;
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            count_nxt = count_r - CNT_W'(1);
            res_nxt   = '{found: 1'b1, changed: 1'b1, full_refused: 1'b0,
                          entry_count: COUNT_OUT_W'(count_r - CNT_W'(1))};
            state_nxt = ST_RESP;
          end
        end
      end

      // Hold until the output register can take the result.
      ST_RESP: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
    kind_r    <= kind_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
  end

  assign in_req.ready = (state_r == ST_IDLE);
  assign res_load     = (state_r == ST_RESP) && slot_free;
  assign res          = res_r;

endmodule

`default_nettype wire

@@ design/edge_pair_set.sv @@
// ----------------------------------------------------------------------------
// edge_pair_set
// Ordered, duplicate-free set of directed (source, destination) node pairs.
// ----------------------------------------------------------------------------
// Each request (add, remove or check) returns one result with found, changed,
// full_refused and the entry count after the request. Requests are handled one
// at a time; the store is a single memory with one read and one write port, and
// the scan reads one entry per cycle. A scan that misses reads every stored
// entry, and a hit stops the scan at the matching entry. A remove then shifts
// the entries behind the match down by one place. The result is handed to the
// output register once that register is free, and the next request is taken
// after that. A new request is taken while the previous result still waits in
// the output register.
`default_nettype none

module edge_pair_set
  import eps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  eps_req_if.sink   in_req,
  eps_rsp_if.source out_rsp
);

  eps_mem_req_t     mem_req;
  logic [KEY_W-1:0] rd_data;
  eps_result_t      res;
  logic             res_load;
  logic             slot_free;

  logic        out_valid_r, out_valid_nxt;
  eps_result_t out_res_r;

  eps_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  eps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  assign slot_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.found        = out_res_r.found;
  assign out_rsp.changed      = out_res_r.changed;
  assign out_rsp.full_refused = out_res_r.full_refused;
  assign out_rsp.entry_count  = out_res_r.entry_count;

endmodule

`default_nettype wire

@@ design/eps_check.sv @@
// ----------------------------------------------------------------------------
// eps_check
// Port-level checks on the results of the edge pair set.
// ----------------------------------------------------------------------------
`default_nettype none

module eps_check
  import eps_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic                   out_found,
  input wire logic                   out_changed,
  input wire logic                   out_full_refused,
  input wire logic [COUNT_OUT_W-1:0] out_entry_count
);

  localparam logic [COUNT_OUT_W-1:0] FULL_COUNT = COUNT_OUT_W'(MAX_PAIRS);

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_found, out_changed, out_full_refused, out_entry_count}))
    else $error("result changed while stalled");

  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_refused |->
      !out_found && !out_changed && out_entry_count == FULL_COUNT)
    else $error("refused add without a full store");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= FULL_COUNT)
    else $error("entry count beyond capacity");

  a_remove_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_changed && out_found |-> out_entry_count < FULL_COUNT)
    else $error("remove left a full store");

  a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_changed && !out_found |-> out_entry_count != '0)
    else $error("add left an empty store");

endmodule

bind edge_pair_set eps_check u_eps_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_found        (out_rsp.found),
  .out_changed      (out_rsp.changed),
  .out_full_refused (out_rsp.full_refused),
  .out_entry_count  (out_rsp.entry_count)
);

`default_nettype wire
